[hw/rtl/bfea_pkg.sv]
// Shared types and codes of the best-fit extent allocator.
// No dependencies; imported by every module of the block.
package bfea_pkg;

	// Width of the block-number fields on the ports
	localparam int FIELD_W  = 48;
	localparam int STATUS_W = 3;

	// Request codes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 3'd0,
		ST_NO_FIT    = 3'd1,
		ST_ADDED     = 3'd2,
		ST_FULL      = 3'd3,
		ST_ZERO      = 3'd4
	} status_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LAUNCH,
		S_SCAN,
		S_FINISH
	} state_t;

	// Commands from the sequencer to the cell row
	typedef struct packed {
		logic scan_go;
		logic add_go;
		logic cut_go;
		logic drop_go;
	} cmd_t;

endpackage

[hw/rtl/bfea_cell.sv]
// One slot of the free-range table: holds a start and a length, and takes
// part in the best-fit search token that walks the row. Depends on bfea_pkg.
module bfea_cell #(
	parameter int SLOTS      = 64,
	parameter int BLOCK_BITS = 48,
	parameter int IDX        = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfea_pkg::cmd_t               cmd,
	input  logic [$clog2(SLOTS+1)-1:0]   count,
	input  logic [$clog2(SLOTS)-1:0]     best_idx,
	input  logic [BLOCK_BITS-1:0]        req_start,
	input  logic [BLOCK_BITS-1:0]        req_len,
	input  logic [BLOCK_BITS-1:0]        best_waste,
	input  logic [BLOCK_BITS-1:0]        nxt_start,
	input  logic [BLOCK_BITS-1:0]        nxt_len,
	output logic [BLOCK_BITS-1:0]        slot_start,
	output logic [BLOCK_BITS-1:0]        slot_len,
	input  logic                         tok_in_vld,
	input  logic                         tok_in_found,
	input  logic [BLOCK_BITS-1:0]        tok_in_waste,
	input  logic [$clog2(SLOTS)-1:0]     tok_in_idx,
	input  logic [BLOCK_BITS-1:0]        tok_in_start,
	output logic                         tok_out_vld,
	output logic                         tok_out_found,
	output logic [BLOCK_BITS-1:0]        tok_out_waste,
	output logic [$clog2(SLOTS)-1:0]     tok_out_idx,
	output logic [BLOCK_BITS-1:0]        tok_out_start
);
	import bfea_pkg::*;

	localparam int CNT_W = $clog2(SLOTS+1);
	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [BLOCK_BITS-1:0] start_q;
	logic [BLOCK_BITS-1:0] len_q;
	logic                  vld_q;
	logic                  found_q;
	logic [BLOCK_BITS-1:0] waste_q;
	logic [IDX_W-1:0]      idx_q;
	logic [BLOCK_BITS-1:0] bstart_q;

	logic                  live;
	logic                  fits;
	logic [BLOCK_BITS-1:0] diff;
	logic                  take;

	assign slot_start = start_q;
	assign slot_len   = len_q;

	// Compare this slot's leftover against the best so far
	always_comb begin
		live = MY_CNT < count;
		fits = live && (len_q >= req_len);
		diff = len_q - req_len;
		take = fits && (!tok_in_found || (diff < tok_in_waste));
	end

	// Register the search token, then hand it on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in_vld) begin
			found_q  <= tok_in_found || take;
			waste_q  <= take ? diff : tok_in_waste;
			idx_q    <= take ? MY_IDX : tok_in_idx;
			bstart_q <= take ? start_q : tok_in_start;
		end
	end

	assign tok_out_vld   = vld_q;
	assign tok_out_found = found_q;
	assign tok_out_waste = waste_q;
	assign tok_out_idx   = idx_q;
	assign tok_out_start = bstart_q;

	// Load on add, trim the winner on a partial cut, shift down on removal
	always_ff @(posedge clk) begin
		if (cmd.add_go && (MY_CNT == count)) begin
			start_q <= req_start;
			len_q   <= req_len;
		end else if (cmd.cut_go && (MY_IDX == best_idx)) begin
			start_q <= start_q + req_len;
			len_q   <= best_waste;
		end else if (cmd.drop_go && (MY_IDX >= best_idx)) begin
			start_q <= nxt_start;
			len_q   <= nxt_len;
		end
	end

endmodule

[hw/rtl/bfea_ctrl.sv]
// Sequencer of the allocator: takes requests, launches the search token,
// keeps the fill count and drives the result register. Depends on bfea_pkg.
module bfea_ctrl #(
	parameter int SLOTS      = 64,
	parameter int BLOCK_BITS = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [bfea_pkg::FIELD_W-1:0]        range_start,
	input  logic [bfea_pkg::FIELD_W-1:0]        run_length,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bfea_pkg::STATUS_W-1:0]       status,
	output logic [bfea_pkg::FIELD_W-1:0]        placed_start,
	output bfea_pkg::cmd_t                      cmd,
	output logic [$clog2(SLOTS+1)-1:0]          count,
	output logic [$clog2(SLOTS)-1:0]            best_idx,
	output logic [BLOCK_BITS-1:0]               req_start,
	output logic [BLOCK_BITS-1:0]               req_len,
	output logic [BLOCK_BITS-1:0]               best_waste,
	input  logic                                end_vld,
	input  logic                                end_found,
	input  logic [BLOCK_BITS-1:0]               end_waste,
	input  logic [$clog2(SLOTS)-1:0]            end_idx,
	input  logic [BLOCK_BITS-1:0]               end_start
);
	import bfea_pkg::*;

	localparam int CNT_W = $clog2(SLOTS+1);
	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

	state_t                state_q, state_d;
	logic                  op_q;
	logic [BLOCK_BITS-1:0] rstart_q;
	logic [BLOCK_BITS-1:0] rlen_q;
	logic [CNT_W-1:0]      count_q;
	logic                  found_q;
	logic [BLOCK_BITS-1:0] waste_q;
	logic [IDX_W-1:0]      best_q;
	logic [BLOCK_BITS-1:0] bstart_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [FIELD_W-1:0]    placed_q;

	logic                  accept;
	logic                  push;
	logic                  add_ok;
	status_t               res_status;
	logic [FIELD_W-1:0]    res_placed;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (op == OP_ALLOC) ? S_LAUNCH : S_FINISH;
				end
			end
			S_LAUNCH: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (end_vld) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall    = (state_q != S_IDLE);
		accept      = in_valid && (state_q == S_IDLE);
		push        = (state_q == S_FINISH) && (!out_valid_q || !out_stall);
		add_ok      = (rlen_q != '0) && (count_q != FULL_CNT);
		cmd.scan_go = (state_q == S_LAUNCH);
		cmd.add_go  = push && (op_q == OP_ADD) && add_ok;
		cmd.cut_go  = push && (op_q == OP_ALLOC) && found_q && (waste_q != '0);
		cmd.drop_go = push && (op_q == OP_ALLOC) && found_q && (waste_q == '0);
	end

	// Result of the finished request
	always_comb begin
		res_placed = '0;
		if (op_q == OP_ADD) begin
			if (rlen_q == '0) begin
				res_status = ST_ZERO;
			end else if (count_q == FULL_CNT) begin
				res_status = ST_FULL;
			end else begin
				res_status = ST_ADDED;
			end
		end else if (found_q) begin
			res_status = ST_ALLOCATED;
			res_placed = FIELD_W'(bstart_q);
		end else begin
			res_status = ST_NO_FIT;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.add_go) begin
				count_q <= count_q + ONE_CNT;
			end else if (cmd.drop_go) begin
				count_q <= count_q - ONE_CNT;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the request, the search outcome and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			rstart_q <= BLOCK_BITS'(range_start);
			rlen_q   <= BLOCK_BITS'(run_length);
		end
		if ((state_q == S_SCAN) && end_vld) begin
			found_q  <= end_found;
			waste_q  <= end_waste;
			best_q   <= end_idx;
			bstart_q <= end_start;
		end
		if (push) begin
			status_q <= res_status;
			placed_q <= res_placed;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign placed_start = placed_q;
	assign count        = count_q;
	assign best_idx     = best_q;
	assign req_start    = rstart_q;
	assign req_len      = rlen_q;
	assign best_waste   = waste_q;

endmodule

[hw/rtl/best_fit_extent_allocator_core.sv]
// Best-fit extent allocator: a row of SLOTS table cells and the sequencer.
// Depends on bfea_pkg, bfea_cell and bfea_ctrl.
//
// The free-range table lives in a row of SLOTS cells, one range per cell, in
// insertion order. On an allocate a search token walks the cell row one cell
// a cycle, each cell putting in its leftover if it beats the best so far (the
// lowest slot wins a tie), and the winner is then trimmed or removed, the
// later cells all shifting down by one. One request is in flight at a time;
// the result sits in an output register, so the next request is taken while
// it waits. Entries above the fill count are never looked at, so the table
// needs no clearing after reset.
module best_fit_extent_allocator_core #(
	parameter int SLOTS      = 64,
	parameter int BLOCK_BITS = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [bfea_pkg::FIELD_W-1:0]  range_start,
	input  logic [bfea_pkg::FIELD_W-1:0]  run_length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bfea_pkg::STATUS_W-1:0] status,
	output logic [bfea_pkg::FIELD_W-1:0]  placed_start
);
	import bfea_pkg::*;

	localparam int CNT_W = $clog2(SLOTS+1);
	localparam int IDX_W = $clog2(SLOTS);

	cmd_t                  cmd;
	logic [CNT_W-1:0]      count;
	logic [IDX_W-1:0]      best_idx;
	logic [BLOCK_BITS-1:0] req_start;
	logic [BLOCK_BITS-1:0] req_len;
	logic [BLOCK_BITS-1:0] best_waste;

	logic [SLOTS:0]        tok_vld;
	logic [SLOTS:0]        tok_found;
	logic [BLOCK_BITS-1:0] tok_waste [SLOTS+1];
	logic [IDX_W-1:0]      tok_idx   [SLOTS+1];
	logic [BLOCK_BITS-1:0] tok_start [SLOTS+1];

	logic [BLOCK_BITS-1:0] cell_start [SLOTS];
	logic [BLOCK_BITS-1:0] cell_len   [SLOTS];
	logic [BLOCK_BITS-1:0] nxt_start  [SLOTS];
	logic [BLOCK_BITS-1:0] nxt_len    [SLOTS];

	bfea_ctrl #(
		.SLOTS      (SLOTS),
		.BLOCK_BITS (BLOCK_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.range_start  (range_start),
		.run_length   (run_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.placed_start (placed_start),
		.cmd          (cmd),
		.count        (count),
		.best_idx     (best_idx),
		.req_start    (req_start),
		.req_len      (req_len),
		.best_waste   (best_waste),
		.end_vld      (tok_vld[SLOTS]),
		.end_found    (tok_found[SLOTS]),
		.end_waste    (tok_waste[SLOTS]),
		.end_idx      (tok_idx[SLOTS]),
		.end_start    (tok_start[SLOTS])
	);

	// Inject an empty token at the head of the row
	assign tok_vld[0]   = cmd.scan_go;
	assign tok_found[0] = 1'b0;
	assign tok_waste[0] = '0;
	assign tok_idx[0]   = '0;
	assign tok_start[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		// Feed each cell its upper neighbour for removal; the last keeps its own
		if (i == SLOTS - 1) begin : g_last
			assign nxt_start[i] = cell_start[i];
			assign nxt_len[i]   = cell_len[i];
		end else begin : g_mid
			assign nxt_start[i] = cell_start[i+1];
			assign nxt_len[i]   = cell_len[i+1];
		end

		bfea_cell #(
			.SLOTS      (SLOTS),
			.BLOCK_BITS (BLOCK_BITS),
			.IDX        (i)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.count         (count),
			.best_idx      (best_idx),
			.req_start     (req_start),
			.req_len       (req_len),
			.best_waste    (best_waste),
			.nxt_start     (nxt_start[i]),
			.nxt_len       (nxt_len[i]),
			.slot_start    (cell_start[i]),
			.slot_len      (cell_len[i]),
			.tok_in_vld    (tok_vld[i]),
			.tok_in_found  (tok_found[i]),
			.tok_in_waste  (tok_waste[i]),
			.tok_in_idx    (tok_idx[i]),
			.tok_in_start  (tok_start[i]),
			.tok_out_vld   (tok_vld[i+1]),
			.tok_out_found (tok_found[i+1]),
			.tok_out_waste (tok_waste[i+1]),
			.tok_out_idx   (tok_idx[i+1]),
			.tok_out_start (tok_start[i+1])
		);
	end

	// The fill count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(SLOTS))
		else $error("fill count beyond table size");

	// Only one search token is ever in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one search token in flight");

	// No token is in flight while a new request may be taken
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (tok_vld == '0))
		else $error("search token alive while accepting requests");

	// The table changes by at most one command at a time
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.add_go, cmd.cut_go, cmd.drop_go}))
		else $error("conflicting table updates");

endmodule

[tb/tb_best_fit_extent_allocator_core.sv]
// Self-checking testbench for best_fit_extent_allocator_core: directed and random requests,
// with a best-fit ledger that predicts each result and a scoreboard that checks them in order.
// Depends on bfea_pkg and the allocator core RTL.
`timescale 1ns / 1ps

module tb_best_fit_extent_allocator_core;
	import bfea_pkg::*;

	localparam int TABLE_SLOTS  = 64;
	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 4000;
	localparam logic [FIELD_W-1:0] ALL_ONES = '1;

	typedef struct {
		status_t            status;
		logic [FIELD_W-1:0] placed;
	} alloc_result_t;

	// Best-fit ledger: mirrors the free-range table and queues the results it predicts
	class extent_ledger;
		logic [FIELD_W-1:0] ext_start [TABLE_SLOTS];
		logic [FIELD_W-1:0] ext_len [TABLE_SLOTS];
		int                 live;
		alloc_result_t      due [$];
		int                 mismatches;
		int                 tally [5];

		function new();
			live = 0;
			mismatches = 0;
			foreach (tally[i]) tally[i] = 0;
		endfunction

		function void report(string what);
			mismatches++;
			$display("[%0t] MISMATCH: %s", $time, what);
		endfunction

		// Apply one accepted request to the table and queue its result
		function void note_request(logic req_op, logic [FIELD_W-1:0] start,
				logic [FIELD_W-1:0] length);
			alloc_result_t      r;
			bit                 found;
			int                 best;
			logic [FIELD_W-1:0] waste;
			logic [FIELD_W-1:0] w;
			r.status = ST_NO_FIT;
			r.placed = '0;
			found = 0;
			best = 0;
			waste = '0;
			if (req_op == OP_ADD) begin
				if (length == '0) begin
					r.status = ST_ZERO;
				end else if (live >= TABLE_SLOTS) begin
					r.status = ST_FULL;
				end else begin
					ext_start[live] = start;
					ext_len[live] = length;
					live++;
					r.status = ST_ADDED;
				end
			end else begin
				// smallest leftover wins, lowest slot on a tie, stop on an exact fit
				for (int i = 0; i < live; i++) begin
					if (ext_len[i] >= length) begin
						w = ext_len[i] - length;
						if (!found || w < waste) begin
							found = 1;
							best = i;
							waste = w;
							if (w == '0) break;
						end
					end
				end
				if (found) begin
					r.status = ST_ALLOCATED;
					r.placed = ext_start[best];
					ext_start[best] = ext_start[best] + length;
					ext_len[best] = waste;
					// close the gap of a used-up range, keeping the order
					if (waste == '0) begin
						for (int i = best; i + 1 < live; i++) begin
							ext_start[i] = ext_start[i + 1];
							ext_len[i] = ext_len[i + 1];
						end
						live--;
					end
				end
			end
			tally[r.status]++;
			due.insert(due.size(), r);
		endfunction

		// Compare one accepted result with the oldest prediction
		function void check_result(logic [STATUS_W-1:0] st, logic [FIELD_W-1:0] ps);
			alloc_result_t want;
			if (due.size() == 0) begin
				report($sformatf("result with no request outstanding, status %0d", st));
				return;
			end
			want = due.pop_front();
			if (st !== want.status)
				report($sformatf("status %0d, expected %0d", st, want.status));
			if (ps !== want.placed)
				report($sformatf("placed_start %h, expected %h", ps, want.placed));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                op = OP_ADD;
	logic [FIELD_W-1:0]  range_start = '0;
	logic [FIELD_W-1:0]  run_length = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [FIELD_W-1:0]  placed_start;

	extent_ledger ledger = new();
	bit           calm_send = 0;
	int           random_items = 0;

	always #4 clk = ~clk;

	best_fit_extent_allocator_core #(
		.SLOTS(TABLE_SLOTS),
		.BLOCK_BITS(FIELD_W)
	) dut (.*);

	function automatic logic [FIELD_W-1:0] rand_field();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[FIELD_W-1:0];
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	// Present one request, hold it until taken, then idle a while
	task automatic send_request(logic req_op, logic [FIELD_W-1:0] start,
			logic [FIELD_W-1:0] length);
		int gap;
		in_valid <= 1'b1;
		op <= req_op;
		range_start <= start;
		run_length <= length;
		do @(posedge clk); while (!(in_valid && !in_stall));
		ledger.note_request(req_op, start, length);
		gap = calm_send ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every predicted result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (ledger.due.size() != 0) @(posedge clk);
	endtask

	// Allocation size drawn mostly from live ranges: exact, shorter, zero or one too long
	function automatic logic [FIELD_W-1:0] pick_alloc_length();
		int                 roll;
		logic [FIELD_W-1:0] room;
		roll = $urandom_range(0, 99);
		if (ledger.live == 0 || roll < 8) begin
			case ($urandom_range(0, 3))
				0: return rand_field();
				1: return ALL_ONES;
				default: return FIELD_W'($urandom_range(0, 40));
			endcase
		end
		room = ledger.ext_len[$urandom_range(0, ledger.live - 1)];
		if (roll < 50) return room;
		if (roll < 85) begin
			if (room > FIELD_W'(8)) return room - FIELD_W'($urandom_range(1, 8));
			return FIELD_W'($urandom_range(1, room[3:0]));
		end
		if (roll < 92) return '0;
		return room + FIELD_W'(1);
	endfunction

	// One random request; a small share is pure noise
	task automatic random_request(int add_pct);
		logic               req_op;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] length;
		int                 roll;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 8) begin
			req_op = 1'($urandom_range(0, 1));
			start = rand_field();
			length = rand_field();
		end else if (roll < add_pct) begin
			req_op = OP_ADD;
			if ($urandom_range(0, 9) == 0) start = ALL_ONES - FIELD_W'($urandom_range(0, 63));
			else start = rand_field();
			roll = $urandom_range(0, 99);
			if (roll < 6) length = '0;
			else if (roll < 12) length = rand_field();
			else if (roll < 14) length = ALL_ONES;
			else length = FIELD_W'($urandom_range(1, 48));
		end else begin
			req_op = OP_ALLOC;
			start = rand_field();
			length = pick_alloc_length();
		end
		send_request(req_op, start, length);
		if (!(req_op == OP_ADD && length == '0)) random_items++;
	endtask

	// Take results, stalling in random bursts with calm stretches between
	initial begin
		int stall_left;
		bit calm_recv;
		stall_left = 0;
		calm_recv = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) ledger.check_result(status, placed_start);
			if ($urandom_range(0, 299) == 0) calm_recv = !calm_recv;
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!calm_recv && $urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	// Watchdog: end the run when nothing moves on either side for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
			else idle++;
		end
		$display("[%0t] Timeout: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int kind;
		int steps;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, zero length, field extremes, ties, exact fit, start wrap
		send_request(OP_ALLOC, '0, 48'd5);
		send_request(OP_ADD, 48'h1234, '0);
		send_request(OP_ADD, '0, ALL_ONES);
		send_request(OP_ADD, 48'hFFFF_FFFF_FFF0, 48'h40);
		send_request(OP_ADD, 48'h1000, 48'd8);
		send_request(OP_ADD, 48'h2000, 48'd8);
		send_request(OP_ADD, 48'h3000, 48'd3);
		send_request(OP_ALLOC, ALL_ONES, '0);
		send_request(OP_ALLOC, '0, 48'd8);
		send_request(OP_ALLOC, '0, 48'd8);
		send_request(OP_ALLOC, '0, 48'd2);
		send_request(OP_ALLOC, '0, 48'h20);
		send_request(OP_ALLOC, '0, 48'h20);
		send_request(OP_ALLOC, '0, ALL_ONES);
		send_request(OP_ALLOC, '0, ALL_ONES);
		send_request(OP_ALLOC, '0, 48'd1);
		send_request(OP_ADD, ALL_ONES, 48'd1);
		send_request(OP_ALLOC, '0, 48'd1);
		send_request(OP_ADD, 48'h100, 48'd10);
		send_request(OP_ADD, 48'h200, 48'd10);
		send_request(OP_ALLOC, '0, 48'd4);
		send_request(OP_ALLOC, '0, 48'd12);
		drain_results();

		// Random phases: fill to full, drain to empty, or mixed churn
		while (random_items < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			calm_send = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 5) == 0) drain_results();
			if (kind < 2) begin
				while (ledger.live < TABLE_SLOTS) random_request(100);
				repeat ($urandom_range(1, 4)) random_request(100);
			end else if (kind < 4) begin
				steps = 0;
				while (ledger.live > 0 && steps < 300) begin
					random_request(0);
					steps++;
				end
				repeat ($urandom_range(1, 3)) random_request(0);
			end else begin
				repeat ($urandom_range(20, 80))
					random_request(ledger.live < 4 ? 75 : 50);
			end
		end
		calm_send = 0;
		drain_results();
		repeat (TABLE_SLOTS + 8) @(posedge clk);

		$display(
			"Covered %0d requests: %0d allocated, %0d no fit, %0d added, %0d full, %0d zero length",
			ledger.tally[ST_ALLOCATED] + ledger.tally[ST_NO_FIT] + ledger.tally[ST_ADDED]
			+ ledger.tally[ST_FULL] + ledger.tally[ST_ZERO],
			ledger.tally[ST_ALLOCATED], ledger.tally[ST_NO_FIT], ledger.tally[ST_ADDED],
			ledger.tally[ST_FULL], ledger.tally[ST_ZERO]);
		$display("Mismatches found: %0d", ledger.mismatches);
		if (ledger.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
